[design/kmcd_pkg.sv]
// Shared types, constants and the keymap lookup for the key matrix change detector.
package kmcd_pkg;

    // Field widths of the scan request and of the change request.
    localparam int FIELD_COLS = 14;
    localparam int ROW_W      = 3;
    localparam int COL_W      = 4;
    localparam int CODE_W     = 8;

    // Keymap ROM geometry and the code reported for unmapped positions.
    localparam int ROM_ROWS = 6;
    localparam int ROM_COLS = 14;
    localparam logic [CODE_W-1:0] CODE_UNKNOWN = 8'd240;

    typedef logic [FIELD_COLS-1:0] col_vec_t;

    // Linux input codes, one row of the matrix per entry.
    localparam logic [CODE_W-1:0] KEYMAP [ROM_ROWS][ROM_COLS] = '{
        '{8'd1,  8'd59,  8'd60, 8'd61, 8'd62,  8'd63,  8'd64,
          8'd65, 8'd66,  8'd67, 8'd68, 8'd87,  8'd88,  8'd111},
        '{8'd41, 8'd2,   8'd3,  8'd4,  8'd5,   8'd6,   8'd7,
          8'd8,  8'd9,   8'd10, 8'd11, 8'd12,  8'd13,  8'd14},
        '{8'd15, 8'd16,  8'd17, 8'd18, 8'd19,  8'd20,  8'd21,
          8'd22, 8'd23,  8'd24, 8'd25, 8'd26,  8'd27,  8'd43},
        '{8'd58, 8'd30,  8'd31, 8'd32, 8'd33,  8'd34,  8'd35,
          8'd36, 8'd37,  8'd38, 8'd39, 8'd40,  8'd28,  8'd240},
        '{8'd42, 8'd44,  8'd45, 8'd46, 8'd47,  8'd48,  8'd49,
          8'd50, 8'd51,  8'd52, 8'd53, 8'd54,  8'd240, 8'd240},
        '{8'd29, 8'd125, 8'd56, 8'd57, 8'd100, 8'd240, 8'd97,
          8'd240, 8'd240, 8'd240, 8'd240, 8'd240, 8'd240, 8'd240}
    };

    // Work loaded into the event generator: changed columns, new levels, row.
    typedef struct packed {
        col_vec_t           diff;
        col_vec_t           now;
        logic [ROW_W-1:0]   row;
    } ev_load_t;

    // Keycode of a matrix position; positions outside the ROM are unknown.
    function automatic logic [CODE_W-1:0] keycode(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
        logic [CODE_W-1:0] code;
        code = CODE_UNKNOWN;
        if ((32'(row) < ROM_ROWS) && (32'(col) < ROM_COLS))
        begin
            code = KEYMAP[row][col];
        end
        return code;
    endfunction

endpackage

[design/kmcd_if.sv]
// Valid/ready channel interfaces for scan requests and key change requests.
interface kmcd_scan_if;
    logic                           valid;
    logic                           ready;
    logic [kmcd_pkg::ROW_W-1:0]     row_index;
    logic [kmcd_pkg::FIELD_COLS-1:0] column_levels;

    modport source (output valid, row_index, column_levels, input ready);
    modport sink   (input valid, row_index, column_levels, output ready);
endinterface

interface kmcd_change_if;
    logic                           valid;
    logic                           ready;
    logic [kmcd_pkg::CODE_W-1:0]    key_code;
    logic                           key_pressed;
    logic [kmcd_pkg::ROW_W-1:0]     key_row;
    logic [kmcd_pkg::COL_W-1:0]     key_column;
    logic                           last_event;

    modport source (output valid, key_code, key_pressed, key_row, key_column, last_event,
                    input ready);
    modport sink   (input valid, key_code, key_pressed, key_row, key_column, last_event,
                    output ready);
endinterface

[design/key_matrix_change_detector_top.sv]
// Top level of the key matrix change detector.
// Each scan request carries one matrix row and its active-low column levels. The row's
// stored key state is read from a small synchronous memory in the cycle the request is
// taken, compared in the next cycle, and the new state is written back as the compare
// stage hands the row on; a write to the row being read in the same cycle is forwarded.
// A scan request is accepted every cycle as long as the event generator keeps up: a row
// with no change, or with a row number of ROWS or more, does not stall and yields nothing.
// A row with n changed keys yields n change requests, one per cycle while the receiver
// is ready, in ascending column order, the last flagged; the first is offered once the
// row has passed the compare stage and been loaded into the event generator. The single
// event generator sets the sustained rate at one change request per cycle while the
// receiver is ready. Stored states read as released after reset with no clearing pass.
module key_matrix_change_detector_top #(
    parameter int ROWS    = 6,
    parameter int COLUMNS = 14
) (
    input  logic          clk,
    input  logic          rst_n,
    kmcd_scan_if.sink     scan,
    kmcd_change_if.source change
);
    localparam int ADDR_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ACT_COLS = (COLUMNS > kmcd_pkg::FIELD_COLS) ? kmcd_pkg::FIELD_COLS
                                                                  : COLUMNS;
    localparam kmcd_pkg::col_vec_t COL_MASK =
        kmcd_pkg::col_vec_t'((33'd1 << ACT_COLS) - 33'd1);

    logic                        in_fire;
    logic                        in_range;
    logic [ADDR_W-1:0]           scan_addr;
    logic                        s1_valid_reg;
    logic                        s1_range_reg;
    logic [kmcd_pkg::ROW_W-1:0]  s1_row_reg;
    kmcd_pkg::col_vec_t          s1_levels_reg;
    logic [ADDR_W-1:0]           s1_addr;
    kmcd_pkg::col_vec_t          rd_data;
    kmcd_pkg::col_vec_t          old_state;
    kmcd_pkg::col_vec_t          now_state;
    kmcd_pkg::col_vec_t          diff;
    logic                        fwd_valid_reg;
    logic [ADDR_W-1:0]           fwd_addr_reg;
    kmcd_pkg::col_vec_t          fwd_data_reg;
    logic                        s1_fire;
    logic                        wr_en;
    logic                        ev_load_valid;
    logic                        ev_can_load;
    kmcd_pkg::ev_load_t          ev_load;

    // Request intake and memory read address.
    assign in_fire   = scan.valid && scan.ready;
    assign in_range  = (32'(scan.row_index) < ROWS);
    assign scan_addr = ADDR_W'(scan.row_index);
    assign s1_addr   = ADDR_W'(s1_row_reg);

    kmcd_state_mem #(
        .ROWS (ROWS)
    ) u_state_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_fire && in_range),
        .rd_addr (scan_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (s1_addr),
        .wr_data (now_state)
    );

    // Compare stage: the most recent write wins over the memory read for the same row.
    assign old_state = (fwd_valid_reg && (fwd_addr_reg == s1_addr)) ? fwd_data_reg : rd_data;
    assign now_state = ~s1_levels_reg & COL_MASK;
    assign diff      = (now_state ^ old_state) & COL_MASK;

    assign ev_load_valid = s1_valid_reg && s1_range_reg && (diff != '0);
    assign ev_load.diff  = diff;
    assign ev_load.now   = now_state;
    assign ev_load.row   = s1_row_reg;

    assign s1_fire    = s1_valid_reg && (!ev_load_valid || ev_can_load);
    assign wr_en      = s1_fire && s1_range_reg;
    assign scan.ready = !s1_valid_reg || s1_fire;

    // Compare stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (wr_en)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    // Compare stage payload and write forwarding data.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_range_reg  <= in_range;
            s1_row_reg    <= scan.row_index;
            s1_levels_reg <= scan.column_levels;
        end
        if (wr_en)
        begin
            fwd_addr_reg <= s1_addr;
            fwd_data_reg <= now_state;
        end
    end

    kmcd_event_gen u_event_gen (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (ev_load_valid),
        .load       (ev_load),
        .can_load   (ev_can_load),
        .change     (change)
    );
endmodule

[design/kmcd_state_mem.sv]
// Row state memory: registered synchronous read, one write port, per-row valid bits.
module kmcd_state_mem #(
    parameter int ROWS = 6
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              rd_en,
    input  logic [(ROWS > 1 ? $clog2(ROWS) : 1)-1:0] rd_addr,
    output kmcd_pkg::col_vec_t                rd_data,
    input  logic                              wr_en,
    input  logic [(ROWS > 1 ? $clog2(ROWS) : 1)-1:0] wr_addr,
    input  kmcd_pkg::col_vec_t                wr_data
);
    kmcd_pkg::col_vec_t mem [ROWS];
    logic [ROWS-1:0]    written_reg;
    kmcd_pkg::col_vec_t rd_data_reg;
    logic               rd_hit_reg;

    // A row that was never written since reset reads as all released.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else if (wr_en)
        begin
            written_reg[wr_addr] <= 1'b1;
        end
    end

    // Storage and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_hit_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            rd_hit_reg <= written_reg[rd_addr];
        end
    end

    assign rd_data = rd_hit_reg ? rd_data_reg : '0;
endmodule

[design/kmcd_event_gen.sv]
// Event generator: walks the changed columns of one row, lowest first, one request a cycle unless the receiver stalls.
module kmcd_event_gen (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load_valid,
    input  kmcd_pkg::ev_load_t   load,
    output logic                 can_load,
    kmcd_change_if.source        change
);
    kmcd_pkg::col_vec_t          diff_reg;
    kmcd_pkg::col_vec_t          diff_next;
    kmcd_pkg::col_vec_t          now_reg;
    logic [kmcd_pkg::ROW_W-1:0]  row_reg;
    kmcd_pkg::col_vec_t          low_bit;
    kmcd_pkg::col_vec_t          rest;
    logic [kmcd_pkg::COL_W-1:0]  col;
    logic                        out_fire;
    logic                        is_last;

    // Isolate the lowest pending column and encode its position.
    assign low_bit = diff_reg & (~diff_reg + kmcd_pkg::col_vec_t'(1));
    assign rest    = diff_reg & ~low_bit;
    assign is_last = (rest == '0);

    always_comb
    begin
        col = '0;
        for (int i = 0; i < kmcd_pkg::FIELD_COLS; i++)
        begin
            if (low_bit[i])
            begin
                col = col | kmcd_pkg::COL_W'(i);
            end
        end
    end

    // Change request driven straight from the held row.
    assign change.valid       = (diff_reg != '0);
    assign change.key_code    = kmcd_pkg::keycode(row_reg, col);
    assign change.key_pressed = |(now_reg & low_bit);
    assign change.key_row     = row_reg;
    assign change.key_column  = col;
    assign change.last_event  = is_last;

    assign out_fire = change.valid && change.ready;
    assign can_load = !change.valid || (out_fire && is_last);

    always_comb
    begin
        diff_next = diff_reg;
        if (load_valid && can_load)
        begin
            diff_next = load.diff;
        end
        else if (out_fire)
        begin
            diff_next = rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_reg <= '0;
        end
        else
        begin
            diff_reg <= diff_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_valid && can_load)
        begin
            now_reg <= load.now;
            row_reg <= load.row;
        end
    end
endmodule

[design/kmcd_checker.sv]
// Port-level checker for the key matrix change detector, bound to the top level.
module kmcd_checker #(
    parameter int ROWS    = 6,
    parameter int COLUMNS = 14
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        change_valid,
    input logic                        change_ready,
    input logic [kmcd_pkg::CODE_W-1:0] key_code,
    input logic                        key_pressed,
    input logic [kmcd_pkg::ROW_W-1:0]  key_row,
    input logic [kmcd_pkg::COL_W-1:0]  key_column,
    input logic                        last_event
);
    localparam int ACT_COLS = (COLUMNS > kmcd_pkg::FIELD_COLS) ? kmcd_pkg::FIELD_COLS
                                                                  : COLUMNS;

    // A pending change request is held until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        change_valid && !change_ready |=> change_valid)
        else $error("change request dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        change_valid && !change_ready |=>
            $stable(key_code) && $stable(key_pressed) && $stable(key_row) &&
            $stable(key_column) && $stable(last_event))
        else $error("change request payload moved while stalled");

    // A reported position always lies in the scanned part of the matrix.
    assert property (@(posedge clk) disable iff (!rst_n)
        change_valid |-> (32'(key_row) < ROWS) && (32'(key_column) < ACT_COLS))
        else $error("change reported outside the matrix");

    // The keycode matches the keymap at the reported position.
    assert property (@(posedge clk) disable iff (!rst_n)
        change_valid |-> key_code == kmcd_pkg::keycode(key_row, key_column))
        else $error("keycode does not match keymap");

    // Within one row, events leave in strictly ascending column order.
    assert property (@(posedge clk) disable iff (!rst_n)
        change_valid && change_ready && !last_event ##1 change_valid |->
            (key_row == $past(key_row)) && (key_column > $past(key_column)))
        else $error("events of one row out of column order");
endmodule

bind key_matrix_change_detector_top kmcd_checker #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
) u_kmcd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .change_valid (change.valid),
    .change_ready (change.ready),
    .key_code     (change.key_code),
    .key_pressed  (change.key_pressed),
    .key_row      (change.key_row),
    .key_column   (change.key_column),
    .last_event   (change.last_event)
);

[verif/tb_top.sv]
// Self-checking testbench for the key matrix change detector top level.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_ROWS     = 6;
    localparam int NUM_COLS     = 14;
    localparam int RANDOM_SCANS = 200;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 20;

    // One key change request as the block should emit it.
    typedef struct packed {
        logic [kmcd_pkg::CODE_W-1:0] code;
        logic                        pressed;
        logic [kmcd_pkg::ROW_W-1:0]  row;
        logic [kmcd_pkg::COL_W-1:0]  col;
        logic                        last;
    } key_change_t;

    // Tracks the pressed keys of every row and the change requests still owed.
    class key_event_tracker;
        logic [kmcd_pkg::FIELD_COLS-1:0] pressed_keys [NUM_ROWS];
        logic [kmcd_pkg::CODE_W-1:0]     key_codes [NUM_ROWS][NUM_COLS];
        key_change_t                     pending_changes [$];
        int unsigned                     mismatches;

        function new();
            foreach (pressed_keys[r])
            begin
                pressed_keys[r] = '0;
            end
            mismatches = 0;
            // Expected keymap, Linux input codes; 240 marks an unmapped key.
            key_codes = '{
                '{1, 59, 60, 61, 62, 63, 64, 65, 66, 67, 68, 87, 88, 111},
                '{41, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14},
                '{15, 16, 17, 18, 19, 20, 21, 22, 23, 24, 25, 26, 27, 43},
                '{58, 30, 31, 32, 33, 34, 35, 36, 37, 38, 39, 40, 28, 240},
                '{42, 44, 45, 46, 47, 48, 49, 50, 51, 52, 53, 54, 240, 240},
                '{29, 125, 56, 57, 100, 240, 97, 240, 240, 240, 240, 240, 240, 240}
            };
        endfunction

        // Works out the change requests that an accepted scan causes.
        function void note_scan(logic [kmcd_pkg::ROW_W-1:0] row,
                                logic [kmcd_pkg::FIELD_COLS-1:0] levels);
            logic [kmcd_pkg::FIELD_COLS-1:0] now_keys;
            logic [kmcd_pkg::FIELD_COLS-1:0] changed;
            key_change_t                     item;
            // Rows past the matrix are ignored entirely.
            if (int'(row) >= NUM_ROWS)
            begin
                return;
            end
            now_keys = ~levels;
            changed  = now_keys ^ pressed_keys[row];
            for (int c = 0; c < NUM_COLS; c++)
            begin
                if (changed[c])
                begin
                    item.code    = key_codes[row][c];
                    item.pressed = now_keys[c];
                    item.row     = row;
                    item.col     = kmcd_pkg::COL_W'(c);
                    item.last    = ((changed >> (c + 1)) == '0);
                    pending_changes.push_back(item);
                end
            end
            pressed_keys[row] = now_keys;
        endfunction

        // Compares an accepted change request with the oldest one owed.
        function void check_change(key_change_t got);
            key_change_t want;
            if (pending_changes.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected change: code %0d pressed %0d row %0d col %0d last %0d",
                         $time, got.code, got.pressed, got.row, got.col, got.last);
                return;
            end
            want = pending_changes.pop_front();
            if (got !== want)
            begin
                mismatches++;
                $display("%0t: mismatch, expected code %0d pressed %0d row %0d col %0d last %0d",
                         $time, want.code, want.pressed, want.row, want.col, want.last);
                $display("%0t: mismatch, actual   code %0d pressed %0d row %0d col %0d last %0d",
                         $time, got.code, got.pressed, got.row, got.col, got.last);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    kmcd_scan_if   scan_bus ();
    kmcd_change_if change_bus ();

    key_event_tracker tracker;

    int unsigned sender_idle_pct;
    int unsigned receiver_stall_pct;
    bit          hold_request;

    key_matrix_change_detector_top #(
        .ROWS    (NUM_ROWS),
        .COLUMNS (NUM_COLS)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .scan   (scan_bus),
        .change (change_bus)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // Offers one scan request, idling first at random; returns at the falling edge
    // after acceptance with valid still high.
    task automatic drive_scan(input logic [kmcd_pkg::ROW_W-1:0] row,
                              input logic [kmcd_pkg::FIELD_COLS-1:0] levels);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            scan_bus.valid <= 1'b0;
            @(negedge clk);
        end
        scan_bus.valid         <= 1'b1;
        scan_bus.row_index     <= row;
        scan_bus.column_levels <= levels;
        @(posedge clk);
        while (!scan_bus.ready)
        begin
            @(posedge clk);
        end
        tracker.note_scan(row, levels);
        @(negedge clk);
    endtask

    // Picks the next random scan: half small changes to a real row, plus noise.
    task automatic random_scan(output logic [kmcd_pkg::ROW_W-1:0] row,
                               output logic [kmcd_pkg::FIELD_COLS-1:0] levels);
        int unsigned                     pick;
        logic [kmcd_pkg::FIELD_COLS-1:0] flips;
        pick  = $urandom_range(99);
        row   = kmcd_pkg::ROW_W'($urandom_range(NUM_ROWS - 1));
        flips = '0;
        if (pick < 50)
        begin
            // One to three keys change.
            repeat ($urandom_range(3, 1))
            begin
                flips[$urandom_range(NUM_COLS - 1)] = 1'b1;
            end
            levels = ~(tracker.pressed_keys[row] ^ flips);
        end
        else if (pick < 65)
        begin
            levels = kmcd_pkg::FIELD_COLS'($urandom);
        end
        else if (pick < 75)
        begin
            // Row unchanged.
            levels = ~tracker.pressed_keys[row];
        end
        else if (pick < 87)
        begin
            // Whole row pressed or released.
            levels = $urandom_range(1) ? '0 : '1;
        end
        else
        begin
            // Row number past the matrix.
            row    = kmcd_pkg::ROW_W'($urandom_range(7, NUM_ROWS));
            levels = kmcd_pkg::FIELD_COLS'($urandom);
        end
    endtask

    // Receiver: random stalls, plus a long hold-off on request.
    initial
    begin
        int unsigned hold_left;
        hold_left        = 0;
        change_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                change_bus.ready <= 1'b0;
            end
            else
            begin
                change_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // Check every accepted change request.
    always @(posedge clk)
    begin
        if (rst_n && change_bus.valid && change_bus.ready)
        begin
            tracker.check_change('{change_bus.key_code, change_bus.key_pressed,
                                   change_bus.key_row, change_bus.key_column,
                                   change_bus.last_event});
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    // Main sequence.
    initial
    begin
        logic [kmcd_pkg::ROW_W-1:0]      row;
        logic [kmcd_pkg::FIELD_COLS-1:0] levels;
        int unsigned                     idle_pcts [4];
        int unsigned                     stall_pcts [4];
        int unsigned                     counted;

        tracker                = new();
        sender_idle_pct        = 0;
        receiver_stall_pct     = 0;
        hold_request           = 1'b0;
        scan_bus.valid         = 1'b0;
        scan_bus.row_index     = '0;
        scan_bus.column_levels = '0;
        rst_n                  = 1'b0;
        idle_pcts  = '{0, 65, 0, 34};
        stall_pcts = '{0, 0, 65, 34};

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed scans: reset state, full rows, ignored rows, single keys, patterns.
        drive_scan(3'd0, '1);
        drive_scan(3'd0, '0);
        drive_scan(3'd0, '0);
        drive_scan(3'd0, '1);
        for (int r = 1; r < NUM_ROWS; r++)
        begin
            drive_scan(kmcd_pkg::ROW_W'(r), '0);
        end
        drive_scan(3'd6, '0);
        drive_scan(3'd7, '0);
        for (int r = 1; r < NUM_ROWS; r++)
        begin
            drive_scan(kmcd_pkg::ROW_W'(r), '1);
        end
        drive_scan(3'd3, ~(14'h1 << 13));
        drive_scan(3'd2, ~14'h1);
        drive_scan(3'd4, 14'h2AAA);
        drive_scan(3'd4, 14'h1555);
        drive_scan(3'd3, '1);

        // Random phases under different idling; the first one carries a long hold-off.
        for (int p = 0; p < 4; p++)
        begin
            sender_idle_pct    = idle_pcts[p];
            receiver_stall_pct = stall_pcts[p];
            if (p == 0)
            begin
                hold_request = 1'b1;
            end
            counted = 0;
            while (counted < RANDOM_SCANS / 4)
            begin
                random_scan(row, levels);
                drive_scan(row, levels);
                if (int'(row) < NUM_ROWS)
                begin
                    counted++;
                end
            end
        end
        scan_bus.valid <= 1'b0;

        // Drain, then give late extras a chance to show up.
        while (tracker.pending_changes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (tracker.mismatches == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
